>>> hw/rtl/morse_character_keyer_defines.svh
// ----------------------------------------------------------------------------
// Morse character keyer assertion macros
// Clocked property checks, switched off with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MCK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("morse_character_keyer: property violated");
`define MCK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("morse_character_keyer: property violated");
`else
`define MCK_ASSERT(label, clk, rst, prop)
`define MCK_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hw/rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse character keyer package
// Word types, controller/datapath signal groups and the pattern table.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int CHAR_W = 8;
   localparam int PAT_W  = 23;
   localparam int IDX_W  = 6;

   localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_LONG  = 8'h21;
   localparam logic [IDX_W-1:0]  IDX_SPACE  = 6'd36;
   localparam logic [IDX_W-1:0]  IDX_LONG   = 6'd37;
   localparam logic [PAT_W-1:0]  PAT_SPACE  = 23'h10;
   localparam logic [PAT_W-1:0]  PAT_LONG   = 23'h80;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              phrase_start;
   } req_word_type;

   typedef struct packed {
      logic key_on;
      logic char_done;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic last_slot;
   } status_type;

   function automatic logic [IDX_W-1:0] table_index(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] idx;
      begin
         idx = {{(CHAR_W-IDX_W){1'b0}}, IDX_SPACE};
         case (c) inside
            CODE_SPACE:     idx = {{(CHAR_W-IDX_W){1'b0}}, IDX_SPACE};
            CODE_LONG:      idx = {{(CHAR_W-IDX_W){1'b0}}, IDX_LONG};
            [8'h30:8'h39]:  idx = c - 8'd22;
            [8'h61:8'h7A]:  idx = c - 8'h61;
            [8'h41:8'h5A]:  idx = c - 8'd65;
            default:        idx = {{(CHAR_W-IDX_W){1'b0}}, IDX_SPACE};
         endcase
         return idx[IDX_W-1:0];
      end
   endfunction

   function automatic logic [PAT_W-1:0] pattern_lookup(input logic [IDX_W-1:0] idx);
      logic [PAT_W-1:0] pat;
      begin
         case (idx)
            6'd0:    pat = 23'h11D;
            6'd1:    pat = 23'h1157;
            6'd2:    pat = 23'h45D7;
            6'd3:    pat = 23'h457;
            6'd4:    pat = 23'h11;
            6'd5:    pat = 23'h1175;
            6'd6:    pat = 23'h1177;
            6'd7:    pat = 23'h455;
            6'd8:    pat = 23'h45;
            6'd9:    pat = 23'h11DDD;
            6'd10:   pat = 23'h11D7;
            6'd11:   pat = 23'h115D;
            6'd12:   pat = 23'h477;
            6'd13:   pat = 23'h117;
            6'd14:   pat = 23'h4777;
            6'd15:   pat = 23'h45DD;
            6'd16:   pat = 23'h11D77;
            6'd17:   pat = 23'h45D;
            6'd18:   pat = 23'h115;
            6'd19:   pat = 23'h47;
            6'd20:   pat = 23'h475;
            6'd21:   pat = 23'h11D5;
            6'd22:   pat = 23'h11DD;
            6'd23:   pat = 23'h4757;
            6'd24:   pat = 23'h11DD7;
            6'd25:   pat = 23'h4577;
            6'd26:   pat = 23'h477777;
            6'd27:   pat = 23'h11DDDD;
            6'd28:   pat = 23'h47775;
            6'd29:   pat = 23'h11DD5;
            6'd30:   pat = 23'h4755;
            6'd31:   pat = 23'h1155;
            6'd32:   pat = 23'h4557;
            6'd33:   pat = 23'h11577;
            6'd34:   pat = 23'h45777;
            6'd35:   pat = 23'h117777;
            IDX_SPACE: pat = PAT_SPACE;
            IDX_LONG:  pat = PAT_LONG;
            default: pat = PAT_SPACE;
         endcase
         return pat;
      end
   endfunction

endpackage

>>> hw/rtl/mck_ctrl.sv
// ----------------------------------------------------------------------------
// Morse character keyer controller
// Sequences load of one character and the slot-by-slot output run.
// ----------------------------------------------------------------------------
module mck_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mck_pkg::status_type status,
   output mck_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd.load  = 1'b0;
      cmd.shift = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (status.last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/mck_dp.sv
// ----------------------------------------------------------------------------
// Morse character keyer datapath
// Pattern lookup, gap memory and the slot shift register.
// ----------------------------------------------------------------------------
module mck_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  mck_pkg::cmd_type      cmd,
   input  mck_pkg::req_word_type req_data,
   output mck_pkg::rsp_word_type rsp_data,
   output mck_pkg::status_type   status
);

   logic [mck_pkg::PAT_W-1:0]  word_ff;
   logic [mck_pkg::PAT_W-1:0]  word_in;
   logic                       prev_was_gap_ff;
   logic                       prev_was_gap_in;
   logic                       prev_eff;
   logic [mck_pkg::CHAR_W-1:0] code_eff;
   logic                       last_slot;

   always_comb begin
      prev_eff = prev_was_gap_ff & ~req_data.phrase_start;
      code_eff = req_data.char_code;
      if ((req_data.char_code == mck_pkg::CODE_SPACE) && prev_eff) begin
         code_eff = mck_pkg::CODE_LONG;
      end
      prev_was_gap_in = prev_was_gap_ff;
      word_in         = word_ff;
      if (cmd.load) begin
         prev_was_gap_in = (code_eff == mck_pkg::CODE_SPACE) ||
                           (code_eff == mck_pkg::CODE_LONG);
         word_in = mck_pkg::pattern_lookup(mck_pkg::table_index(code_eff));
      end else if (cmd.shift) begin
         word_in = {1'b0, word_ff[mck_pkg::PAT_W-1:1]};
      end
   end

   assign last_slot = (word_ff[mck_pkg::PAT_W-1:1] == {{(mck_pkg::PAT_W-2){1'b0}}, 1'b1});

   assign rsp_data.key_on    = word_ff[0];
   assign rsp_data.char_done = last_slot;
   assign status.last_slot   = last_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_was_gap_ff <= 1'b0;
      end else begin
         prev_was_gap_ff <= prev_was_gap_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

>>> hw/rtl/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// Morse character keyer
// The first slot word is valid the cycle after a character is taken.
// Each character sends N = 4..22 slots from the shift register, one slot per
// cycle while rsp_ready is high. Synchronous reset clears gap.
// ----------------------------------------------------------------------------
`include "morse_character_keyer_defines.svh"

module morse_character_keyer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mck_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mck_pkg::rsp_word_type rsp_data
);

   mck_pkg::cmd_type    cmd;
   mck_pkg::status_type status;

   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mck_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .status   (status)
   );

   `MCK_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid))
   `MCK_ASSERT(a_load_sends, clock, reset, (req_valid && req_ready) |=> rsp_valid)
   `MCK_ASSERT(a_done_idles, clock, reset,
      (rsp_valid && rsp_ready && rsp_data.char_done) |=> req_ready)
   `MCK_ASSERT(a_run_continues, clock, reset,
      (rsp_valid && rsp_ready && !rsp_data.char_done) |=> rsp_valid)

endmodule
